// ----- rtl/acl_pkg.sv -----
package acl_pkg;

    localparam logic [1:0] FUNC_RESOLVE = 2'd0;
    localparam logic [1:0] FUNC_LEARN   = 2'd1;
    localparam logic [1:0] FUNC_ARP     = 2'd2;
    localparam logic [1:0] FUNC_UNUSED  = 2'd3;

    localparam logic [2:0] ST_HIT_RESOLVED = 3'd0;
    localparam logic [2:0] ST_HIT_WAITING  = 3'd1;
    localparam logic [2:0] ST_NEW_WAITING  = 3'd2;
    localparam logic [2:0] ST_STORED       = 3'd3;
    localparam logic [2:0] ST_NOT_STORED   = 3'd4;
    localparam logic [2:0] ST_REJECTED     = 3'd5;

    localparam logic [1:0] KIND_FREE     = 2'd0;
    localparam logic [1:0] KIND_RESOLVED = 2'd1;
    localparam logic [1:0] KIND_WAITING  = 2'd2;

    localparam logic [1:0] MODE_HIT   = 2'd0;
    localparam logic [1:0] MODE_FRONT = 2'd1;
    localparam logic [1:0] MODE_BACK  = 2'd2;

    localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
    localparam logic [15:0] ARP_OP_REPLY   = 16'd2;
    localparam logic [15:0] ARP_HTYPE_ETH  = 16'd1;
    localparam logic [15:0] ARP_PTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  ARP_HLEN       = 8'd6;
    localparam logic [7:0]  ARP_PLEN       = 8'd4;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] peer_ip;
        logic [47:0] peer_mac;
        logic        force_req;
        logic [31:0] dest_ip;
        logic [15:0] arp_opcode;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [7:0]  hw_len;
        logic [7:0]  proto_len;
    } acl_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [47:0] mac_out;
        logic        send_reply;
        logic        flush_queued;
    } acl_rsp_t;

    // Datapath commands issued by the controller.
    typedef struct packed {
        logic scan_start;   // clear scan results and start at entry zero
        logic scan_step;    // compare one entry and advance
        logic rank_start;
        logic rank_step;    // adjust one entry's rank and advance
        logic commit;       // write the chosen entry
    } acl_cmd_t;

    // Datapath status returned to the controller.
    typedef struct packed {
        logic scan_last;
        logic rank_last;
        logic hit;
        logic hit_waiting;
        logic have_free;
        logic have_lru;
    } acl_sts_t;

endpackage

// ----- rtl/acl_datapath.sv -----
module acl_datapath #(
    parameter int ENTRIES = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  acl_pkg::acl_req_t   req,
    input  logic [1:0]          mode,
    input  logic                evict,
    input  acl_pkg::acl_cmd_t   cmd,
    output acl_pkg::acl_sts_t   sts,
    output logic [47:0]         hit_mac
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    logic [31:0] ip_mem   [ENTRIES];
    logic [47:0] mac_mem  [ENTRIES];
    logic [IW-1:0] rank_mem [ENTRIES];
    logic [1:0]  kind_reg [ENTRIES];

    logic [CW-1:0] used_reg;
    logic [IW-1:0] ptr_reg;
    logic          hit_reg, free_reg, lru_reg;
    logic [IW-1:0] hit_idx_reg, free_idx_reg, lru_idx_reg, hit_rank_reg;
    logic          hit_wait_reg;
    logic [47:0]   hit_mac_reg;

    logic          rd_scan_reg, rd_rank_reg;
    logic [IW-1:0] rd_idx_reg, rd_rk_reg;
    logic [31:0]   rd_ip_reg;
    logic [47:0]   rd_mac_reg;
    logic [1:0]    rd_kind_reg;

    logic [IW-1:0] last_idx;
    logic [IW-1:0] tgt_idx;
    logic          rd_used;
    logic          rank_bump;
    logic          rank_we;
    logic [IW-1:0] rank_wa, rank_wd;

    assign last_idx = IW'(ENTRIES - 1);
    assign rd_used  = rd_kind_reg != acl_pkg::KIND_FREE;
    assign tgt_idx  = hit_reg ? hit_idx_reg : (free_reg ? free_idx_reg : lru_idx_reg);

    assign sts.scan_last   = ptr_reg == last_idx;
    assign sts.rank_last   = ptr_reg == last_idx;
    assign sts.hit         = hit_reg;
    assign sts.hit_waiting = hit_wait_reg;
    assign sts.have_free   = free_reg;
    assign sts.have_lru    = lru_reg;
    assign hit_mac         = hit_mac_reg;

    always_comb begin
        rank_bump = 1'b0;
        if (rd_used) begin
            if (mode == acl_pkg::MODE_HIT) begin
                rank_bump = rd_rk_reg < hit_rank_reg;
            end else if (mode == acl_pkg::MODE_FRONT) begin
                rank_bump = !(evict && rd_idx_reg == lru_idx_reg);
            end
        end
    end

    always_comb begin
        rank_we = 1'b0;
        rank_wa = rd_idx_reg;
        rank_wd = rd_rk_reg + 1'b1;
        if (cmd.commit) begin
            rank_we = 1'b1;
            rank_wa = tgt_idx;
            if (mode == acl_pkg::MODE_BACK) begin
                rank_wd = evict ? IW'(used_reg - 1'b1) : IW'(used_reg);
            end else begin
                rank_wd = '0;
            end
        end else if (rd_rank_reg && rank_bump) begin
            rank_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_step || cmd.rank_step) begin
            rd_idx_reg  <= ptr_reg;
            rd_ip_reg   <= ip_mem[ptr_reg];
            rd_mac_reg  <= mac_mem[ptr_reg];
            rd_rk_reg   <= rank_mem[ptr_reg];
            rd_kind_reg <= kind_reg[ptr_reg];
        end
        if (rank_we) begin
            rank_mem[rank_wa] <= rank_wd;
        end
        if (cmd.commit) begin
            if (mode == acl_pkg::MODE_HIT) begin
                if (req.func != acl_pkg::FUNC_RESOLVE) begin
                    mac_mem[tgt_idx] <= req.peer_mac;
                end
            end else begin
                ip_mem[tgt_idx]  <= req.peer_ip;
                mac_mem[tgt_idx] <= (mode == acl_pkg::MODE_FRONT) ? req.peer_mac : 48'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg     <= '0;
            used_reg    <= '0;
            hit_reg     <= 1'b0;
            free_reg    <= 1'b0;
            lru_reg     <= 1'b0;
            rd_scan_reg <= 1'b0;
            rd_rank_reg <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                kind_reg[i] <= acl_pkg::KIND_FREE;
            end
        end else begin
            rd_scan_reg <= cmd.scan_step;
            rd_rank_reg <= cmd.rank_step;
            if (cmd.scan_start || cmd.rank_start) begin
                ptr_reg <= '0;
            end
            if (cmd.scan_step || cmd.rank_step) begin
                ptr_reg <= ptr_reg + 1'b1;
            end
            if (cmd.scan_start) begin
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
                lru_reg  <= 1'b0;
            end
            if (rd_scan_reg) begin
                if (rd_used && !hit_reg && rd_ip_reg == req.peer_ip) begin
                    hit_reg      <= 1'b1;
                    hit_idx_reg  <= rd_idx_reg;
                    hit_rank_reg <= rd_rk_reg;
                    hit_wait_reg <= rd_kind_reg == acl_pkg::KIND_WAITING;
                    hit_mac_reg  <= rd_mac_reg;
                end
                if (!rd_used && !free_reg) begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= rd_idx_reg;
                end
                if (rd_used && !lru_reg && CW'(rd_rk_reg) == used_reg - 1'b1) begin
                    lru_reg     <= 1'b1;
                    lru_idx_reg <= rd_idx_reg;
                end
            end
            if (cmd.commit) begin
                if (mode == acl_pkg::MODE_HIT) begin
                    if (req.func != acl_pkg::FUNC_RESOLVE) begin
                        kind_reg[tgt_idx] <= acl_pkg::KIND_RESOLVED;
                    end
                end else if (mode == acl_pkg::MODE_FRONT) begin
                    kind_reg[tgt_idx] <= acl_pkg::KIND_RESOLVED;
                    used_reg <= evict ? used_reg : used_reg + 1'b1;
                end else begin
                    kind_reg[tgt_idx] <= acl_pkg::KIND_WAITING;
                    used_reg <= evict ? used_reg : used_reg + 1'b1;
                end
            end
        end
    end

endmodule

// ----- rtl/acl_ctrl.sv -----
module acl_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [31:0]        own_ip,
    input  logic               s_valid,
    output logic               s_ready,
    input  acl_pkg::acl_req_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output acl_pkg::acl_rsp_t  m_data,
    output acl_pkg::acl_req_t  req,
    output logic [1:0]         mode,
    output logic               evict,
    output acl_pkg::acl_cmd_t  cmd,
    input  acl_pkg::acl_sts_t  sts,
    input  logic [47:0]        hit_mac
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_DECIDE   = 3'd2;
    localparam logic [2:0] S_RANK     = 3'd3;
    localparam logic [2:0] S_COMMIT   = 3'd4;
    localparam logic [2:0] S_OUT      = 3'd5;
    localparam logic [2:0] S_SCAN_END = 3'd6;
    localparam logic [2:0] S_RANK_END = 3'd7;

    logic [2:0] state_reg, state_next;
    acl_pkg::acl_req_t req_reg;
    acl_pkg::acl_rsp_t rsp_reg, rsp_next;
    logic [1:0] mode_reg, mode_next;
    logic evict_reg, evict_next;
    logic valid_reg, valid_next;
    logic hdr_ok, force_eff, is_req;

    assign req     = req_reg;
    assign mode    = mode_reg;
    assign evict   = evict_reg;
    assign m_valid = valid_reg;
    assign m_data  = rsp_reg;
    assign s_ready = state_reg == S_IDLE && !valid_reg;

    assign hdr_ok = req_reg.hw_type == acl_pkg::ARP_HTYPE_ETH
        && req_reg.proto_type == acl_pkg::ARP_PTYPE_IPV4
        && req_reg.hw_len == acl_pkg::ARP_HLEN && req_reg.proto_len == acl_pkg::ARP_PLEN
        && (req_reg.arp_opcode == acl_pkg::ARP_OP_REQUEST
            || req_reg.arp_opcode == acl_pkg::ARP_OP_REPLY);
    assign force_eff = req_reg.func == acl_pkg::FUNC_RESOLVE || (req_reg.func == acl_pkg::FUNC_LEARN
        ? req_reg.force_req : req_reg.dest_ip == own_ip);
    assign is_req = req_reg.func == acl_pkg::FUNC_ARP && req_reg.dest_ip == own_ip
        && req_reg.arp_opcode == acl_pkg::ARP_OP_REQUEST && hdr_ok;

    always_comb begin
        state_next = state_reg;
        rsp_next   = rsp_reg;
        mode_next  = mode_reg;
        evict_next = evict_reg;
        valid_next = valid_reg;
        cmd        = '0;
        if (valid_reg && m_ready) begin
            valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready && s_data.func != acl_pkg::FUNC_UNUSED) begin
                    cmd.scan_start = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last) begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                rsp_next = '0;
                rsp_next.send_reply = is_req;
                evict_next = 1'b0;
                cmd.rank_start = 1'b1;
                state_next = S_RANK;
                if (req_reg.func == acl_pkg::FUNC_ARP && !hdr_ok) begin
                    rsp_next.status = acl_pkg::ST_REJECTED;
                    state_next = S_OUT;
                end else if (sts.hit) begin
                    mode_next = acl_pkg::MODE_HIT;
                    if (req_reg.func == acl_pkg::FUNC_RESOLVE) begin
                        rsp_next.status  = sts.hit_waiting ? acl_pkg::ST_HIT_WAITING
                                                           : acl_pkg::ST_HIT_RESOLVED;
                        rsp_next.mac_out = sts.hit_waiting ? 48'd0 : hit_mac;
                    end else begin
                        rsp_next.status = acl_pkg::ST_STORED;
                        rsp_next.flush_queued = 1'b1;
                    end
                end else if (!sts.have_free && !(force_eff && sts.have_lru)) begin
                    rsp_next.status = acl_pkg::ST_NOT_STORED;
                    state_next = S_OUT;
                end else begin
                    evict_next = !sts.have_free;
                    if (req_reg.func == acl_pkg::FUNC_RESOLVE) begin
                        mode_next = acl_pkg::MODE_BACK;
                        rsp_next.status = acl_pkg::ST_NEW_WAITING;
                        state_next = S_COMMIT;
                    end else begin
                        mode_next = acl_pkg::MODE_FRONT;
                        rsp_next.status = acl_pkg::ST_STORED;
                    end
                end
            end
            S_RANK: begin
                cmd.rank_step = 1'b1;
                if (sts.rank_last) begin
                    state_next = S_RANK_END;
                end
            end
            S_RANK_END: begin
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!valid_reg) begin
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
            mode_reg  <= acl_pkg::MODE_HIT;
            evict_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            mode_reg  <= mode_next;
            evict_reg <= evict_next;
        end
        rsp_reg <= rsp_next;
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == S_IDLE) else $error("ready outside idle");
    a_commit_after: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> state_reg == S_OUT) else $error("commit sequencing");
    a_valid_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(valid_reg) |-> $past(state_reg) == S_OUT) else $error("stray beat");

endmodule

// ----- rtl/arp_cache_lru_core.sv -----
// ARP cache with move-to-front recency order. One beat is accepted at a time. A lookup
// or learn that touches the recency order runs two passes before its result beat: one
// comparator scans the table one entry per cycle, then a second pass adjusts one rank
// per cycle, both on registered table reads. A resolve miss skips the rank pass; a
// rejected header or a learn that cannot be stored skips the rank pass and the table
// write. The next beat is accepted only after the result beat has been taken. own_ip
// must be written while idle; the block does not enforce this. Func code 3 is consumed
// without a result beat.
module arp_cache_lru_core #(
    parameter int ENTRIES = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  acl_pkg::acl_req_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output acl_pkg::acl_rsp_t  m_data
);

    logic [31:0] own_ip_reg;
    acl_pkg::acl_req_t req;
    logic [1:0] mode;
    logic evict;
    acl_pkg::acl_cmd_t cmd;
    acl_pkg::acl_sts_t sts;
    logic [47:0] hit_mac;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_ip_reg <= '0;
        end else if (cfg_valid) begin
            own_ip_reg <= cfg_data;
        end
    end

    acl_ctrl u_ctrl (
        .aclk, .aresetn, .own_ip(own_ip_reg),
        .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .req, .mode, .evict, .cmd, .sts, .hit_mac
    );

    acl_datapath #(.ENTRIES(ENTRIES)) u_dp (
        .aclk, .aresetn, .req, .mode, .evict, .cmd, .sts, .hit_mac
    );

endmodule
